// ===== design/motor_mode_supervisor_defines.svh =====
// Assertion macros shared by the motor mode supervisor RTL.
`ifndef MOTOR_MODE_SUPERVISOR_DEFINES_SVH
`define MOTOR_MODE_SUPERVISOR_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define MMS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("motor_mode_supervisor: invariant violated");

// Property whose consequent holds in the cycle after the antecedent.
`define MMS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("motor_mode_supervisor: sequence check failed");

`endif

// ===== design/mms_pkg.sv =====
// Types and reset constants of the motor mode supervisor.
`default_nettype none
package mms_pkg;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_REFRESH    = 3'd1,
    KIND_REFERENCE  = 3'd2,
    KIND_SATURATION = 3'd3,
    KIND_ENABLE     = 3'd4,
    KIND_BUTTON     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    MODE_CONTROL = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_SAFE    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ACK_NONE          = 2'd0,
    ACK_LIMITS_REJECT = 2'd1,
    ACK_LIMITS_ACCEPT = 2'd2,
    ACK_ENABLE        = 2'd3
  } ack_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] rpm_l;
    logic signed [15:0] rpm_r;
    logic signed [13:0] lim_lo;
    logic signed [13:0] lim_hi;
    logic [6:0]         duty_l;
    logic [6:0]         duty_r;
    logic               wd_run;
    logic [15:0]        wd_cnt;
    logic               prev_btn;
  } mms_state_t;

  typedef struct packed {
    logic [6:0]         duty_l;
    logic [6:0]         duty_r;
    mode_e              mode;
    ack_e               ack;
    logic signed [15:0] rpm_l;
    logic signed [15:0] rpm_r;
  } mms_result_t;

  localparam logic [15:0] TimeoutReset = 16'd250;

  localparam mms_state_t StateReset = '{
    mode:     MODE_CONTROL,
    rpm_l:    16'sd1000,
    rpm_r:    -16'sd7000,
    lim_lo:   -14'sd5000,
    lim_hi:   14'sd5000,
    duty_l:   7'd50,
    duty_r:   7'd50,
    wd_run:   1'b1,
    wd_cnt:   16'd0,
    prev_btn: 1'b1
  };

endpackage
`default_nettype wire

// ===== design/mms_step.sv =====
// Next-state and result logic for one supervisor event.
`default_nettype none
module mms_step import mms_pkg::*; (
  input  mms_state_t         state_i,
  input  logic [15:0]        timeout_i,
  input  logic [2:0]         kind_i,
  input  logic signed [15:0] value_a_i,
  input  logic signed [15:0] value_b_i,
  input  logic               button_level_i,
  output mms_state_t         state_o,
  output mms_result_t        result_o
);

  localparam logic signed [15:0] FeasMin    = -16'sd8000;
  localparam logic signed [15:0] FeasMax    = 16'sd8000;
  localparam logic signed [15:0] DutyOffset = 16'sd10100;
  // floor(x / 25) for x < 2263 as (x * 1311) >> 15
  localparam logic [22:0]        Recip25    = 23'd1311;

  function automatic logic signed [15:0] clamp_rpm(input logic signed [15:0] r,
                                                   input logic signed [13:0] lo,
                                                   input logic signed [13:0] hi);
    logic signed [15:0] lo_x;
    logic signed [15:0] hi_x;
    logic signed [15:0] c;
    lo_x = 16'(lo);
    hi_x = 16'(hi);
    c = r;
    if (c > hi_x) c = hi_x;
    if (c < lo_x) c = lo_x;
    return c;
  endfunction

  // (r + 10100) / 200 with r within the feasible range: shift right by 3, then divide by 25
  function automatic logic [6:0] duty_of(input logic signed [15:0] r);
    logic signed [15:0] s;
    logic [11:0]        x;
    logic [22:0]        p;
    s = r + DutyOffset;
    x = s[14:3];
    p = 23'(x) * Recip25;
    return p[21:15];
  endfunction

  mms_state_t         nxt;
  ack_e               ack;
  logic               do_refresh;
  logic               zero_speeds;
  logic [15:0]        cnt_inc;
  logic               lim_bad;
  logic signed [15:0] clamp_l;
  logic signed [15:0] clamp_r;

  assign cnt_inc = (state_i.wd_cnt != 16'hFFFF) ? state_i.wd_cnt + 16'd1 : state_i.wd_cnt;
  assign lim_bad = (value_a_i >= value_b_i) || (value_a_i < FeasMin) ||
                   (value_b_i > FeasMax) || (value_a_i > 16'sd0) || (value_b_i < 16'sd0);

  always_comb begin
    nxt         = state_i;
    ack         = ACK_NONE;
    do_refresh  = 1'b0;
    zero_speeds = 1'b0;
    case (kind_i)
      KIND_TICK: begin
        if (state_i.wd_run) begin
          nxt.wd_cnt = cnt_inc;
          if (cnt_inc >= timeout_i) begin
            nxt.wd_cnt  = '0;
            nxt.wd_run  = 1'b0;
            nxt.mode    = MODE_TIMEOUT;
            zero_speeds = 1'b1;
            do_refresh  = 1'b1;
          end
        end
      end
      KIND_REFRESH: do_refresh = 1'b1;
      KIND_REFERENCE: begin
        nxt.wd_cnt = '0;
        if (state_i.mode != MODE_SAFE) begin
          nxt.rpm_l = value_a_i;
          nxt.rpm_r = value_b_i;
        end
        if (state_i.mode == MODE_TIMEOUT) begin
          nxt.wd_run = 1'b1;
          nxt.mode   = MODE_CONTROL;
        end
      end
      KIND_SATURATION: begin
        if (lim_bad) begin
          ack = ACK_LIMITS_REJECT;
        end else begin
          nxt.lim_lo = value_a_i[13:0];
          nxt.lim_hi = value_b_i[13:0];
          do_refresh = 1'b1;
          ack        = ACK_LIMITS_ACCEPT;
        end
      end
      KIND_ENABLE: begin
        if (state_i.mode == MODE_SAFE) begin
          nxt.wd_cnt  = '0;
          nxt.wd_run  = 1'b1;
          nxt.mode    = MODE_CONTROL;
          zero_speeds = 1'b1;
          do_refresh  = 1'b1;
          ack         = ACK_ENABLE;
        end
      end
      KIND_BUTTON: begin
        if (state_i.prev_btn && !button_level_i) begin
          nxt.mode    = MODE_SAFE;
          nxt.wd_run  = 1'b0;
          nxt.wd_cnt  = '0;
          zero_speeds = 1'b1;
          do_refresh  = 1'b1;
        end
        nxt.prev_btn = button_level_i;
      end
      default: ;
    endcase
    if (zero_speeds) begin
      nxt.rpm_l = '0;
      nxt.rpm_r = '0;
    end
  end

  assign clamp_l = clamp_rpm(nxt.rpm_l, nxt.lim_lo, nxt.lim_hi);
  assign clamp_r = clamp_rpm(nxt.rpm_r, nxt.lim_lo, nxt.lim_hi);

  always_comb begin
    state_o = nxt;
    if (do_refresh) begin
      state_o.rpm_l  = clamp_l;
      state_o.rpm_r  = clamp_r;
      state_o.duty_l = duty_of(clamp_l);
      state_o.duty_r = duty_of(clamp_r);
    end
  end

  always_comb begin
    result_o.duty_l = state_o.duty_l;
    result_o.duty_r = state_o.duty_r;
    result_o.mode   = state_o.mode;
    result_o.ack    = ack;
    result_o.rpm_l  = state_o.rpm_l;
    result_o.rpm_r  = state_o.rpm_r;
  end

endmodule
`default_nettype wire

// ===== design/motor_mode_supervisor.sv =====
// An accepted event passes the input register and then the result register before
// out_valid_o rises; out_stall_i can hold it in the input register between the two.
// Throughput: one event per cycle while out_stall_i does not hold the result register;
// input register, one step of logic, result register. The input side keeps accepting
// while the result register waits on out_stall_i as long as the stage between them is free.
// Reset: asynchronous, active low; control mode, speeds 1000 and -7000, limits +-5000,
`default_nettype none
`include "motor_mode_supervisor_defines.svh"
module motor_mode_supervisor import mms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [15:0] value_a_i,
  input  logic signed [15:0] value_b_i,
  input  logic               button_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         duty_left_o,
  output logic [6:0]         duty_right_o,
  output logic [1:0]         mode_o,
  output logic [1:0]         ack_code_o,
  output logic signed [15:0] speed_left_o,
  output logic signed [15:0] speed_right_o
);

  // duties 50, watchdog running, timeout 250 ticks; no pending transaction.

  logic               item_vld_q;
  logic [2:0]         kind_q;
  logic signed [15:0] value_a_q;
  logic signed [15:0] value_b_q;
  logic               level_q;
  logic [15:0]        timeout_q;
  mms_state_t         state_q;
  mms_state_t         state_d;
  mms_result_t        res_q;
  mms_result_t        res_d;
  logic               out_vld_q;
  logic               fire;
  logic               load;

  // process the held event when the result register is free or draining
  assign fire       = item_vld_q && (!out_vld_q || !out_stall_i);
  assign load       = !item_vld_q || fire;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (load) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      kind_q    <= kind_i;
      value_a_q <= value_a_i;
      value_b_q <= value_b_i;
      level_q   <= button_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  mms_step u_step (
    .state_i        (state_q),
    .timeout_i      (timeout_q),
    .kind_i         (kind_q),
    .value_a_i      (value_a_q),
    .value_b_i      (value_b_q),
    .button_level_i (level_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign duty_left_o   = res_q.duty_l;
  assign duty_right_o  = res_q.duty_r;
  assign mode_o        = res_q.mode;
  assign ack_code_o    = res_q.ack;
  assign speed_left_o  = res_q.rpm_l;
  assign speed_right_o = res_q.rpm_r;

  `MMS_ASSERT_ALWAYS(a_safe_speeds_zero,
                     (state_q.mode != MODE_SAFE) ||
                     (state_q.rpm_l == 16'sd0 && state_q.rpm_r == 16'sd0))
  `MMS_ASSERT_ALWAYS(a_watchdog_stopped, (state_q.mode == MODE_CONTROL) || !state_q.wd_run)
  `MMS_ASSERT_ALWAYS(a_limits_straddle_zero,
                     (state_q.lim_lo <= 14'sd0) && (state_q.lim_hi >= 14'sd0))
  `MMS_ASSERT_NEXT(a_enable_ack,
                   fire && kind_q == KIND_ENABLE && state_q.mode == MODE_SAFE,
                   out_vld_q && res_q.ack == ACK_ENABLE && res_q.mode == MODE_CONTROL)

endmodule
`default_nettype wire
